FILE: rtl/core/deqrm_pkg.sv
`default_nettype none

package deqrm_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_REMOVE     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COMPACT,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0] removed_count;
    logic [CountW-1:0] length;
    logic              is_empty;
    logic              rejected;
  } out_item_t;

  // Broadcast controls shared by every cell of the chain.
  typedef struct packed {
    logic mark;
    logic compact;
    logic push_front;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/deqrm_cell.sv
`default_nettype none

module deqrm_cell
  import deqrm_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cell_ctrl_t               ctrl_i,
  input  wire logic                     in_use_i,
  input  wire logic                     load_back_i,
  input  wire logic signed [ValueW-1:0] value_i,
  input  wire logic signed [ValueW-1:0] prev_data_i,
  input  wire logic signed [ValueW-1:0] next_data_i,
  input  wire logic                     next_doomed_i,
  input  wire logic                     hole_i,
  output logic                          hole_o,
  output logic signed [ValueW-1:0]      data_o,
  output logic                          doomed_o
);

  logic signed [ValueW-1:0] data_q, data_d;
  logic                     doomed_q, doomed_d;

  // A gap at or ahead of this cell pulls the tail one step toward the head.
  assign hole_o   = hole_i | doomed_q;
  assign data_o   = data_q;
  assign doomed_o = doomed_q;

  always_comb begin
    data_d   = data_q;
    doomed_d = doomed_q;
    if (ctrl_i.mark) begin
      doomed_d = in_use_i && (data_q == value_i);
    end else if (ctrl_i.compact && hole_o) begin
      data_d   = next_data_i;
      doomed_d = next_doomed_i;
    end else if (ctrl_i.push_front) begin
      data_d = prev_data_i;
    end else if (load_back_i) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      doomed_q <= 1'b0;
    end else begin
      doomed_q <= doomed_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/deque_with_remove_matching_unit.sv
`default_nettype none

// Ordered store of up to DEPTH signed 32-bit values held in a chain of cells, head in
// cell 0. Commands: push front, push back, and remove-all-equal, which deletes every
// match, keeps the order of the rest and reports the number deleted. Each transaction
// yields one result with the new length and an empty flag; a push into a full store
// is rejected and flagged. One command is in work at a time. A push is reported from
// its execute step; a remove first marks every match, then compacts, as the chain
// closes one gap per cycle by shifting every cell behind the first gap one place
// toward the head. The result sits in an output register, so the next command can
// start while it waits; a new result waits in the unit if the previous one is still
// stalled. No clearing pass after reset.
module deque_with_remove_matching_unit
  import deqrm_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int unsigned OccW = $clog2(DEPTH + 1);

  state_e                   state_q, state_d;
  logic [1:0]               cmd_q;
  logic signed [ValueW-1:0] value_q;
  logic [OccW-1:0]          occ_q, occ_d;
  logic [OccW-1:0]          rmcnt_q, rmcnt_d;
  logic                     out_valid_q;
  out_item_t                out_q, out_d;

  logic       in_fire;
  logic       full;
  logic       is_push;
  logic       any_doomed;
  logic       slot_free;
  logic       report_fire;
  logic       rej_q, rej_d;
  cell_ctrl_t ctrl;

  logic signed [ValueW-1:0] data_w   [DEPTH];
  logic                     doomed_w [DEPTH];
  logic                     hole_w   [DEPTH+1];

  logic [OccW+CountW-1:0] len_ext;
  logic [OccW+CountW-1:0] rm_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign full       = (occ_q == OccW'(DEPTH));
  assign is_push    = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_BACK);
  assign any_doomed = hole_w[DEPTH];
  assign slot_free  = !out_valid_q || !out_stall_i;

  // Cell chain.
  assign hole_w[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValueW-1:0] prev_data;
    logic signed [ValueW-1:0] next_data;
    logic                     next_doomed;

    if (i == 0) begin : g_head
      assign prev_data = value_q;
    end else begin : g_body
      assign prev_data = data_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_data   = data_w[i];
      assign next_doomed = 1'b0;
    end else begin : g_inner
      assign next_data   = data_w[i+1];
      assign next_doomed = doomed_w[i+1];
    end

    deqrm_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .in_use_i      (OccW'(i) < occ_q),
      .load_back_i   ((state_q == ST_EXEC) && (cmd_q == CMD_PUSH_BACK) && !full &&
                      (occ_q == OccW'(i))),
      .value_i       (value_q),
      .prev_data_i   (prev_data),
      .next_data_i   (next_data),
      .next_doomed_i (next_doomed),
      .hole_i        (hole_w[i]),
      .hole_o        (hole_w[i+1]),
      .data_o        (data_w[i]),
      .doomed_o      (doomed_w[i])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_q == CMD_REMOVE) state_d = ST_COMPACT;
        else                     state_d = report_fire ? ST_IDLE : ST_REPORT;
      end
      ST_COMPACT: begin
        if (!any_doomed) state_d = report_fire ? ST_IDLE : ST_REPORT;
      end
      ST_REPORT: begin
        if (report_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    ctrl        = '0;
    report_fire = 1'b0;
    occ_d       = occ_q;
    rmcnt_d     = rmcnt_q;
    rej_d       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) rmcnt_d = '0;
      end
      ST_EXEC: begin
        ctrl.mark       = (cmd_q == CMD_REMOVE);
        ctrl.push_front = (cmd_q == CMD_PUSH_FRONT) && !full;
        rej_d           = is_push && full;
        if (is_push && !full) occ_d = occ_q + OccW'(1);
        report_fire     = (cmd_q != CMD_REMOVE) && slot_free;
      end
      ST_COMPACT: begin
        ctrl.compact = 1'b1;
        if (any_doomed) begin
          occ_d   = occ_q - OccW'(1);
          rmcnt_d = rmcnt_q + OccW'(1);
        end
        report_fire = !any_doomed && slot_free;
      end
      ST_REPORT: begin
        // Hold the rejection decided before the push updated the occupancy.
        rej_d       = rej_q;
        report_fire = slot_free;
      end
      default: ;
    endcase
  end

  assign len_ext = {{CountW{1'b0}}, occ_d};
  assign rm_ext  = {{CountW{1'b0}}, rmcnt_d};

  always_comb begin
    out_d.removed_count = rm_ext[CountW-1:0];
    out_d.length        = len_ext[CountW-1:0];
    out_d.is_empty      = (occ_d == '0);
    out_d.rejected      = rej_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      rmcnt_q     <= '0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      rmcnt_q <= rmcnt_d;
      rej_q   <= rej_d;
      if (report_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the command for the duration of the transaction; load the result on report.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= in_item_i.cmd;
      value_q <= in_item_i.value;
    end
    if (report_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(DEPTH))
    else $error("occupancy above DEPTH");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_fire && rej_d |-> full)
    else $error("rejection reported while store not full");

  a_compact_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMPACT) && any_doomed |=> occ_q == $past(occ_q) - OccW'(1))
    else $error("compaction step did not drop one entry");

  a_fire_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_EXEC && rmcnt_q == '0)
    else $error("accepted transaction did not start execution");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
module testbench;
  import deqrm_pkg::*;

  localparam int unsigned ListDepth = 16;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned RandomCmds = 1300;
  localparam int unsigned HoldAfter = 400;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned DrainCycles = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  in_item_t in_item = '0;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_item_t out_item_o;

  deque_with_remove_matching_unit #(
    .DEPTH(ListDepth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_item_o (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the list, head in cell 0.
  logic signed [ValueW-1:0] list_cells[ListDepth];
  int unsigned list_fill = 0;

  in_item_t cmd_backlog[$];
  out_item_t due_reports[$];

  int unsigned errors = 0;
  int unsigned cmds_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned pushes = 0;
  int unsigned rejects = 0;
  int unsigned removes = 0;
  int unsigned deleted = 0;
  int unsigned full_hits = 0;

  function automatic out_item_t apply_list_cmd(in_item_t it);
    out_item_t r;
    int unsigned kept;
    r = '0;
    kept = 0;
    case (it.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        pushes++;
        if (list_fill >= ListDepth) begin
          r.rejected = 1'b1;
          rejects++;
        end else if (it.cmd == CMD_PUSH_FRONT) begin
          for (int i = list_fill; i > 0; i--) list_cells[i] = list_cells[i-1];
          list_cells[0] = it.value;
          list_fill++;
        end else begin
          list_cells[list_fill] = it.value;
          list_fill++;
        end
      end
      CMD_REMOVE: begin
        removes++;
        for (int i = 0; i < list_fill; i++) begin
          if (list_cells[i] != it.value) begin
            list_cells[kept] = list_cells[i];
            kept++;
          end
        end
        r.removed_count = CountW'(list_fill - kept);
        deleted += list_fill - kept;
        list_fill = kept;
      end
      default: ;
    endcase
    if (list_fill == ListDepth) full_hits++;
    r.length = CountW'(list_fill);
    r.is_empty = (list_fill == 0);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Driver
  int unsigned gap_left = 0;
  int unsigned tx_burst = 0;
  logic tx_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      tx_done = 1'b0;
      if (in_valid && !in_stall_o) begin
        due_reports.push_back(apply_list_cmd(in_item));
        cmds_sent++;
        tx_done = 1'b1;
        if (tx_burst > 0) begin
          tx_burst--;
          gap_left = 0;
        end else if ($urandom_range(0, 39) == 0) begin
          tx_burst = $urandom_range(20, 40);
          gap_left = 0;
        end else begin
          gap_left = pick_gap();
        end
      end
      if (!in_valid || tx_done) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          in_item <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: report %0d field %s: expected %0d, actual %0d",
               $time, reports_seen, name, want, got);
    end
  endtask

  // Monitor
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_burst = 0;
  logic hold_done = 1'b0;
  out_item_t want_rep;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (due_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected report: expected none, actual %p", $time, out_item_o);
        end else begin
          want_rep = due_reports.pop_front();
          check_field("removed_count", want_rep.removed_count, out_item_o.removed_count);
          check_field("length", want_rep.length, out_item_o.length);
          check_field("is_empty", want_rep.is_empty, out_item_o.is_empty);
          check_field("rejected", want_rep.rejected, out_item_o.rejected);
        end
        reports_seen++;
      end
      // Hold off once for a long stretch so the unit backs up into its input.
      if (!hold_done && reports_seen >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (rx_burst > 0) begin
        rx_burst--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 59) == 0) begin
        rx_burst = $urandom_range(20, 50);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_cmd(logic [1:0] cmd, logic [ValueW-1:0] value);
    in_item_t it;
    it.cmd = cmd;
    it.value = value;
    cmd_backlog.push_back(it);
  endtask

  function automatic logic [ValueW-1:0] pick_pool_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return ValueW'($urandom_range(0, 3));
    if (r == 4) return 32'h8000_0000;
    if (r == 5) return 32'h7fff_ffff;
    if (r == 6) return 32'hffff_ffff;
    return $urandom();
  endfunction

  // Stimulus
  initial begin
    logic [ValueW-1:0] pool[4];
    logic [ValueW-1:0] v;
    int unsigned mode;
    int unsigned run;
    int unsigned r;
    int unsigned made;
    logic [1:0] c;

    // Directed: empty store, extremes, no match, full store, mass removal.
    queue_cmd(CMD_REMOVE, 32'd0);
    queue_cmd(CmdUnused, 32'h1234_5678);
    queue_cmd(CMD_PUSH_FRONT, 32'h7fff_ffff);
    queue_cmd(CMD_PUSH_BACK, 32'h8000_0000);
    queue_cmd(CMD_PUSH_FRONT, 32'hffff_ffff);
    queue_cmd(CMD_PUSH_BACK, 32'd0);
    queue_cmd(CMD_REMOVE, 32'd5);
    queue_cmd(CMD_REMOVE, 32'h8000_0000);
    for (int i = 0; i < 13; i++) begin
      queue_cmd((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, 32'd5);
    end
    queue_cmd(CMD_PUSH_FRONT, 32'd9);
    queue_cmd(CMD_PUSH_BACK, 32'd9);
    queue_cmd(CmdUnused, 32'hffff_ffff);
    queue_cmd(CMD_REMOVE, 32'd5);

    // Random: blocks that fill, drain or mix, with values drawn from a small
    // pool so removals find matches, plus some fully random values.
    made = 0;
    while (made < RandomCmds) begin
      mode = $urandom_range(0, 2);
      run = $urandom_range(8, 30);
      for (int i = 0; i < 4; i++) pool[i] = pick_pool_value();
      for (int k = 0; k < run; k++) begin
        r = $urandom_range(0, 99);
        if (r < 5) c = CmdUnused;
        else if ((mode == 0 && r < 90) || (mode == 1 && r < 40) || (mode == 2 && r < 60))
          c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else c = CMD_REMOVE;
        if ($urandom_range(0, 99) < 85) v = pool[$urandom_range(0, 3)];
        else v = $urandom();
        queue_cmd(c, v);
        made++;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (cmd_backlog.size() > 0 || in_valid || due_reports.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (due_reports.size() > 0) begin
      errors++;
      $display("%0t: %0d reports never arrived: expected %p, actual none",
               $time, due_reports.size(), due_reports[0]);
    end
    $display("Covered %0d commands and %0d reports: %0d pushes (%0d rejected), %0d removes",
             cmds_sent, reports_seen, pushes, rejects, removes);
    $display("deleting %0d entries, store full after %0d commands, %0d errors",
             deleted, full_hits, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("Timeout with %0d commands queued and %0d reports due",
             cmd_backlog.size(), due_reports.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
